>>> design/assert_macros.svh
// assert_macros.svh: assertion shorthands shared by the deframer rtl
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

>>> design/pgpdf_pkg.sv
// pgpdf_pkg: types and constants of the packet header deframer
// used by pgpdf_core and pgp_packet_header_deframer_top; no dependencies
`timescale 1ns / 1ps

package pgpdf_pkg;

  // one raw message byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  packet_type;
    logic        new_format;
    logic [2:0]  header_length;
    logic [31:0] content_length;
    logic [7:0]  content_byte;
    logic        last_of_packet;
    logic [1:0]  error_code;
  } out_item_t;

  // result with its valid flag, from the parser to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  // parser phase
  typedef enum logic [2:0] {
    PH_TAG       = 3'd0,
    PH_ACCUM     = 3'd1,
    PH_NEWFIRST  = 3'd2,
    PH_NEWSECOND = 3'd3,
    PH_BODY      = 3'd4,
    PH_DISCARD   = 3'd5
  } phase_e;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_CONTENT = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_INVALID_TAG = 2'd1;
  localparam logic [1:0] ERR_UNSUPP_LEN  = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED   = 2'd3;

  // old-format length type codes (tag bits 1..0)
  localparam logic [1:0] OLD_LEN_ONE  = 2'd0;
  localparam logic [1:0] OLD_LEN_TWO  = 2'd1;
  localparam logic [1:0] OLD_LEN_FOUR = 2'd2;

  // new-format first length byte ranges
  localparam logic [7:0]  NEW_LEN_ONE_MAX  = 8'd191;
  localparam logic [7:0]  NEW_LEN_TWO_MAX  = 8'd223;
  localparam logic [7:0]  NEW_LEN_FIVE     = 8'hFF;
  localparam logic [31:0] NEW_LEN_TWO_BIAS = 32'd192;

endpackage

>>> design/pgpdf_core.sv
// pgpdf_core: header parser state and per-byte decode of the deframer
// depends on pgpdf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pgpdf_core import pgpdf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t in_item_i,
  output res_t     res_o
);

  phase_e      phase_q, phase_d, phase_step;
  logic [2:0]  lbl_q, lbl_d, lbl_s;
  logic [31:0] acc_q, acc_d, acc_s;
  logic [31:0] cl_q, cl_d, cl_s;
  logic [4:0]  type_q, type_d, type_s;
  logic        nf_q, nf_d, nf_s;
  logic [2:0]  hl_q, hl_d, hl_s;

  logic [7:0]  b;
  logic        eom;
  logic        fin, err_v, body_res, trunc_fin, err_any;
  logic [31:0] fin_len;
  logic [1:0]  err_code_s;

  assign b   = in_item_i.data_byte;
  assign eom = in_item_i.end_of_message;

  // per-phase decode of the current byte
  always_comb begin
    fin        = 1'b0;
    fin_len    = '0;
    err_v      = 1'b0;
    err_code_s = ERR_NONE;
    body_res   = 1'b0;
    phase_step = phase_q;
    acc_s      = acc_q;
    lbl_s      = lbl_q;
    cl_s       = cl_q;
    type_s     = type_q;
    nf_s       = nf_q;
    hl_s       = hl_q;
    case (phase_q)
      PH_ACCUM: begin
        acc_s = {acc_q[23:0], b};
        lbl_s = lbl_q - 3'd1;
        if (lbl_s == 3'd0) begin
          fin     = 1'b1;
          fin_len = acc_s;
        end else if (eom) begin
          err_v      = 1'b1;
          err_code_s = ERR_TRUNCATED;
        end
      end
      PH_NEWFIRST: begin
        if (b <= NEW_LEN_ONE_MAX) begin
          hl_s    = 3'd2;
          fin     = 1'b1;
          fin_len = {24'b0, b};
        end else if (b <= NEW_LEN_TWO_MAX) begin
          // two-byte length: high part is first byte minus 192
          hl_s  = 3'd3;
          acc_s = {19'b0, b[4:0], 8'b0};
          if (eom) begin
            err_v      = 1'b1;
            err_code_s = ERR_TRUNCATED;
          end else begin
            phase_step = PH_NEWSECOND;
          end
        end else if (b != NEW_LEN_FIVE) begin
          // partial body length
          err_v      = 1'b1;
          err_code_s = ERR_UNSUPP_LEN;
        end else begin
          hl_s  = 3'd6;
          acc_s = '0;
          lbl_s = 3'd4;
          if (eom) begin
            err_v      = 1'b1;
            err_code_s = ERR_TRUNCATED;
          end else begin
            phase_step = PH_ACCUM;
          end
        end
      end
      PH_NEWSECOND: begin
        fin     = 1'b1;
        fin_len = acc_q + {24'b0, b} + NEW_LEN_TWO_BIAS;
      end
      PH_BODY: begin
        cl_s = cl_q - 32'd1;
        if (cl_s != 32'd0 && eom) begin
          err_v      = 1'b1;
          err_code_s = ERR_TRUNCATED;
        end else begin
          body_res = 1'b1;
          if (cl_s == 32'd0) begin
            phase_step = PH_TAG;
          end
        end
      end
      PH_DISCARD: begin
        if (eom) begin
          phase_step = PH_TAG;
        end
      end
      default: begin
        // tag byte
        if (!b[7]) begin
          err_v      = 1'b1;
          err_code_s = ERR_INVALID_TAG;
        end else if (b[6]) begin
          nf_s   = 1'b1;
          type_s = b[4:0];
          if (eom) begin
            err_v      = 1'b1;
            err_code_s = ERR_TRUNCATED;
          end else begin
            phase_step = PH_NEWFIRST;
          end
        end else begin
          nf_s   = 1'b0;
          type_s = {1'b0, b[5:2]};
          case (b[1:0])
            OLD_LEN_ONE: begin
              hl_s  = 3'd2;
              lbl_s = 3'd1;
            end
            OLD_LEN_TWO: begin
              hl_s  = 3'd3;
              lbl_s = 3'd2;
            end
            OLD_LEN_FOUR: begin
              hl_s  = 3'd5;
              lbl_s = 3'd4;
            end
            default: begin
              // indeterminate length
              err_v      = 1'b1;
              err_code_s = ERR_UNSUPP_LEN;
            end
          endcase
          if (!err_v) begin
            acc_s = '0;
            if (eom) begin
              err_v      = 1'b1;
              err_code_s = ERR_TRUNCATED;
            end else begin
              phase_step = PH_ACCUM;
            end
          end
        end
      end
    endcase
  end

  // a complete header with a body cannot end the message
  assign trunc_fin = fin && (fin_len != 32'd0) && eom;
  assign err_any   = err_v || trunc_fin;

  // next phase
  always_comb begin
    if (err_any) begin
      phase_d = eom ? PH_TAG : PH_DISCARD;
    end else if (fin) begin
      phase_d = (fin_len != 32'd0) ? PH_BODY : PH_TAG;
    end else begin
      phase_d = phase_step;
    end
  end

  // next counters and held header fields
  always_comb begin
    acc_d  = acc_s;
    lbl_d  = lbl_s;
    cl_d   = cl_s;
    type_d = type_s;
    nf_d   = nf_s;
    hl_d   = hl_s;
    if (err_any) begin
      acc_d = '0;
      lbl_d = '0;
      cl_d  = '0;
    end else if (fin) begin
      acc_d = '0;
      lbl_d = '0;
      cl_d  = fin_len;
    end
  end

  // result of this byte
  always_comb begin
    res_o       = '0;
    res_o.valid = err_any || fin || body_res;
    if (err_any) begin
      res_o.item.kind       = KIND_ERROR;
      res_o.item.error_code = trunc_fin ? ERR_TRUNCATED : err_code_s;
    end else if (fin) begin
      res_o.item.kind           = KIND_HEADER;
      res_o.item.packet_type    = type_s;
      res_o.item.new_format     = nf_s;
      res_o.item.header_length  = hl_s;
      res_o.item.content_length = fin_len;
      res_o.item.last_of_packet = (fin_len == 32'd0);
    end else if (body_res) begin
      res_o.item.kind           = KIND_CONTENT;
      res_o.item.packet_type    = type_s;
      res_o.item.new_format     = nf_s;
      res_o.item.header_length  = hl_s;
      res_o.item.content_byte   = b;
      res_o.item.last_of_packet = (cl_s == 32'd0);
    end
  end

  // state registers, advanced once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      lbl_q   <= '0;
      acc_q   <= '0;
      cl_q    <= '0;
      type_q  <= '0;
      nf_q    <= 1'b0;
      hl_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      lbl_q   <= lbl_d;
      acc_q   <= acc_d;
      cl_q    <= cl_d;
      type_q  <= type_d;
      nf_q    <= nf_d;
      hl_q    <= hl_d;
    end
  end

  `ASSERT_CLK(a_body_has_bytes, phase_q == PH_BODY |-> cl_q != 32'd0, "body phase with no bytes left")
  `ASSERT_CLK(a_accum_count, phase_q == PH_ACCUM |-> (lbl_q != 3'd0 && lbl_q <= 3'd4), "length byte count out of range")
  `ASSERT_NEVER(a_discard_silent, step_i && phase_q == PH_DISCARD && res_o.valid, "result while discarding")

endmodule

>>> design/pgp_packet_header_deframer_top.sv
// pgp_packet_header_deframer_top: top level of the packet header deframer
// depends on pgpdf_pkg, pgpdf_core and assert_macros.svh
//
// Usage:
//   in channel:  in_valid_i / in_stall_o / in_item_i carries one message byte
//                and its end-of-message flag per transfer.
//   out channel: out_valid_o / out_stall_i / out_item_o carries one result
//                per transfer: a decoded header, a content byte or an error.
//   A byte produces zero or one result. Results leave from an output
//   register in the cycle after the byte transfer.
//   Throughput is one byte per cycle unless the receiver stalls: the parser
//   steps once per byte; the output register refills in the cycle it drains.
//   While a result waits and the receiver stalls, in_stall_o is raised and
//   the parser state and the waiting result hold.
//   Reset clears the output register and puts the parser in front of a tag
//   byte; no clearing pass is needed. After an error, bytes are dropped
//   without results until a byte that ends the message.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pgp_packet_header_deframer_top import pgpdf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      in_xfer;
  res_t      res;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  // stall input only when a waiting result cannot leave
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  pgpdf_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_xfer),
    .in_item_i (in_item_i),
    .res_o     (res)
  );

  // output register next value
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (in_xfer) begin
      out_valid_d = res.valid;
      out_item_d  = res.item;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ASSERT_CLK(a_err_has_code, out_valid_q && out_item_q.kind == KIND_ERROR |-> out_item_q.error_code != ERR_NONE, "error result without code")
  `ASSERT_CLK(a_content_no_len, out_valid_q && out_item_q.kind == KIND_CONTENT |-> out_item_q.content_length == 32'd0 && out_item_q.error_code == ERR_NONE, "content result with header fields")
  `ASSERT_CLK(a_result_from_byte, $rose(out_valid_q) |-> $past(in_xfer), "result without a byte transfer")

endmodule
